FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define AC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also applies during reset.
`define AC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/acpc_pkg.sv
// ----------------------------------------------------------------------------
// acpc_pkg
// Shared constants, types and helpers of the pattern counter.
// ----------------------------------------------------------------------------
package acpc_pkg;

	localparam int MAX_NODES   = 4096;
	localparam int ALPHABET    = 26;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int NTOT_W      = NODE_W + 1;
	localparam int SYM_W       = 5;
	localparam int CNT_W       = 16;
	localparam int CHR_W       = $clog2(ALPHABET);
	localparam int GOTO_DEPTH  = MAX_NODES * ALPHABET;
	localparam int GOTO_AW     = $clog2(GOTO_DEPTH);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_BUILD   = 2'd1;
	localparam logic [1:0] OP_TEXT    = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} item_t;

	// Flat goto address of (node, symbol).
	function automatic logic [GOTO_AW-1:0] goto_addr(input node_t n,
			input logic [SYM_W-1:0] s);
		logic [GOTO_AW-1:0] base;
		base = GOTO_AW'(n * ALPHABET);
		return base + GOTO_AW'(s);
	endfunction

endpackage

FILE: src/acpc_ram.sv
// ----------------------------------------------------------------------------
// acpc_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/acpc_front.sv
// ----------------------------------------------------------------------------
// acpc_front
// Request intake: accepts requests, drops unknown opcodes, queues the rest.
// ----------------------------------------------------------------------------
module acpc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    opcode,
	input  logic [acpc_pkg::SYM_W-1:0]    symbol,
	input  logic                          last,
	input  logic                          hold,
	input  logic                          pop,
	output logic                          busy,
	output logic                          item_valid,
	output acpc_pkg::item_t               item
);
	import acpc_pkg::*;

	item_t             q_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              accept;
	logic              push;
	logic              pop_ok;

	assign busy       = hold || (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign accept     = start && !busy;
	// drop requests with no meaning right here
	assign push       = accept && (opcode != OP_NONE);
	assign item_valid = (count_q != '0);
	assign pop_ok     = pop && item_valid;
	assign item       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= '{opcode: opcode, symbol: symbol, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: src/acpc_engine.sv
// ----------------------------------------------------------------------------
// acpc_engine
// Back end: trie insert, automaton build, text scan, and the reset clearing
// pass over every store but the BFS queue.
// ----------------------------------------------------------------------------
module acpc_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  acpc_pkg::item_t             item,
	output logic                        pop,
	output logic                        clearing,
	output logic                        done,
	output logic [acpc_pkg::CNT_W-1:0]  match_count,
	output logic                        store_full
);
	import acpc_pkg::*;

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_PCHK  = 15'b000000000000100,
		S_ERD   = 15'b000000000001000,
		S_EWR   = 15'b000000000010000,
		S_R0    = 15'b000000000100000,
		S_R0C   = 15'b000000001000000,
		S_POP   = 15'b000000010000000,
		S_U     = 15'b000000100000000,
		S_F     = 15'b000001000000000,
		S_RC    = 15'b000010000000000,
		S_RCD   = 15'b000100000000000,
		S_RF    = 15'b001000000000000,
		S_TG    = 15'b010000000000000,
		S_TJ    = 15'b100000000000000
	} state_t;

	state_t             state_q;
	logic               tjd_q;
	logic [GOTO_AW-1:0] clr_q;
	item_t              cur_q;
	logic [NTOT_W-1:0]  ntot_q;
	node_t              ins_q;
	node_t              scan_q;
	node_t              j_q;
	node_t              u_q;
	node_t              f_q;
	node_t              ch_q;
	logic [CHR_W-1:0]   chr_q;
	logic [NTOT_W-1:0]  head_q;
	logic [NTOT_W-1:0]  tail_q;
	logic [CNT_W-1:0]   total_q;
	logic               built_q;
	logic               full_q;
	logic               abort_q;
	logic               done_q;
	logic [CNT_W-1:0]   match_q;

	logic               g_we;
	logic [GOTO_AW-1:0] g_waddr;
	logic [GOTO_AW-1:0] g_raddr;
	node_t              g_wdata;
	node_t              g_rdata;
	logic               f_we;
	node_t              f_waddr;
	node_t              f_wdata;
	node_t              f_raddr;
	node_t              f_rdata;
	logic               e_we;
	node_t              e_waddr;
	logic [CNT_W-1:0]   e_wdata;
	node_t              e_raddr;
	logic [CNT_W-1:0]   e_rdata;
	logic               c_we;
	node_t              c_waddr;
	logic               c_wdata;
	logic               c_rdata;
	logic               q_we;
	node_t              q_waddr;
	node_t              q_wdata;
	node_t              q_raddr;
	node_t              q_rdata;

	logic               item_sym_ok;
	logic               low_clr;
	logic [NTOT_W-1:0]  ntot_inc;
	logic [CNT_W:0]     sum;
	logic               tail_room;
	logic               chr_end;

	assign item_sym_ok = (item.symbol < SYM_W'(ALPHABET));
	assign low_clr     = (clr_q < GOTO_AW'(MAX_NODES));
	assign ntot_inc    = ntot_q + 1'b1;
	assign sum         = {1'b0, total_q} + {1'b0, e_rdata};
	assign tail_room   = (tail_q < NTOT_W'(MAX_NODES));
	assign chr_end     = (chr_q == CHR_W'(ALPHABET - 1));

	assign clearing    = (state_q == S_CLEAR);
	assign pop         = (state_q == S_IDLE) && item_valid;
	assign done        = done_q;
	assign match_count = match_q;
	assign store_full  = full_q;

	// store ports
	always_comb begin
		g_we    = 1'b0;
		g_waddr = '0;
		g_wdata = '0;
		g_raddr = '0;
		f_we    = 1'b0;
		f_waddr = '0;
		f_wdata = '0;
		f_raddr = '0;
		e_we    = 1'b0;
		e_waddr = '0;
		e_wdata = '0;
		e_raddr = '0;
		c_we    = 1'b0;
		c_waddr = '0;
		c_wdata = 1'b0;
		q_we    = 1'b0;
		q_waddr = '0;
		q_wdata = '0;
		q_raddr = '0;
		case (state_q)
			S_CLEAR: begin
				g_we    = 1'b1;
				g_waddr = clr_q;
				f_we    = low_clr;
				e_we    = low_clr;
				c_we    = low_clr;
				f_waddr = clr_q[NODE_W-1:0];
				e_waddr = clr_q[NODE_W-1:0];
				c_waddr = clr_q[NODE_W-1:0];
			end
			S_IDLE: begin
				if (item.opcode == OP_TEXT) begin
					g_raddr = goto_addr(scan_q, item.symbol);
				end else begin
					g_raddr = goto_addr(ins_q, item.symbol);
				end
			end
			S_PCHK: begin
				g_waddr = goto_addr(ins_q, cur_q.symbol);
				g_wdata = ntot_inc[NODE_W-1:0];
				g_we    = (g_rdata == '0) && (ntot_inc < NTOT_W'(MAX_NODES));
			end
			S_ERD: begin
				e_raddr = ins_q;
			end
			S_EWR: begin
				e_waddr = ins_q;
				e_wdata = e_rdata + 1'b1;
				e_we    = !abort_q && (ins_q != '0) && (e_rdata != CNT_MAX);
			end
			S_R0: begin
				g_raddr = goto_addr('0, SYM_W'(chr_q));
			end
			S_R0C: begin
				q_waddr = tail_q[NODE_W-1:0];
				q_wdata = g_rdata;
				q_we    = (g_rdata != '0) && tail_room;
			end
			S_POP: begin
				q_raddr = head_q[NODE_W-1:0];
			end
			S_U: begin
				f_raddr = q_rdata;
			end
			S_RC: begin
				g_raddr = goto_addr(u_q, SYM_W'(chr_q));
			end
			S_RCD: begin
				g_raddr = goto_addr(f_q, SYM_W'(chr_q));
			end
			S_RF: begin
				if (ch_q != '0) begin
					f_we    = 1'b1;
					f_waddr = ch_q;
					f_wdata = g_rdata;
					q_we    = tail_room;
					q_waddr = tail_q[NODE_W-1:0];
					q_wdata = ch_q;
				end else begin
					g_we    = 1'b1;
					g_waddr = goto_addr(u_q, SYM_W'(chr_q));
					g_wdata = g_rdata;
				end
			end
			S_TJ: begin
				if (tjd_q) begin
					c_we    = !c_rdata;
					c_waddr = j_q;
					c_wdata = 1'b1;
				end
				f_raddr = j_q;
				e_raddr = j_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tjd_q   <= 1'b0;
			clr_q   <= '0;
			ntot_q  <= '0;
			ins_q   <= '0;
			scan_q  <= '0;
			j_q     <= '0;
			u_q     <= '0;
			f_q     <= '0;
			ch_q    <= '0;
			chr_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
			built_q <= 1'b0;
			full_q  <= 1'b0;
			abort_q <= 1'b0;
			done_q  <= 1'b0;
			match_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == GOTO_AW'(GOTO_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						case (item.opcode)
							OP_PATTERN: begin
								if (!built_q) begin
									if (abort_q || !item_sym_ok) begin
										abort_q <= 1'b1;
										if (item.last) begin
											ins_q   <= '0;
											abort_q <= 1'b0;
										end
									end else begin
										state_q <= S_PCHK;
									end
								end
							end
							OP_BUILD: begin
								if (!built_q) begin
									ins_q   <= '0;
									abort_q <= 1'b0;
									chr_q   <= '0;
									head_q  <= '0;
									tail_q  <= '0;
									state_q <= S_R0;
								end
							end
							OP_TEXT: begin
								if (item_sym_ok) begin
									state_q <= S_TG;
								end else begin
									scan_q <= '0;
									if (item.last) begin
										done_q  <= 1'b1;
										match_q <= total_q;
										total_q <= '0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PCHK: begin
					if (g_rdata == '0) begin
						if (ntot_inc >= NTOT_W'(MAX_NODES)) begin
							full_q  <= 1'b1;
							abort_q <= 1'b1;
						end else begin
							ntot_q <= ntot_inc;
							ins_q  <= ntot_inc[NODE_W-1:0];
						end
					end else begin
						ins_q <= g_rdata;
					end
					state_q <= cur_q.last ? S_ERD : S_IDLE;
				end
				S_ERD: begin
					state_q <= S_EWR;
				end
				S_EWR: begin
					ins_q   <= '0;
					abort_q <= 1'b0;
					state_q <= S_IDLE;
				end
				S_R0: begin
					state_q <= S_R0C;
				end
				S_R0C: begin
					if ((g_rdata != '0) && tail_room) begin
						tail_q <= tail_q + 1'b1;
					end
					if (chr_end) begin
						chr_q   <= '0;
						state_q <= S_POP;
					end else begin
						chr_q   <= chr_q + 1'b1;
						state_q <= S_R0;
					end
				end
				S_POP: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + 1'b1;
						state_q <= S_U;
					end else begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_U: begin
					u_q     <= q_rdata;
					chr_q   <= '0;
					state_q <= S_F;
				end
				S_F: begin
					f_q     <= f_rdata;
					state_q <= S_RC;
				end
				S_RC: begin
					state_q <= S_RCD;
				end
				S_RCD: begin
					ch_q    <= g_rdata;
					state_q <= S_RF;
				end
				S_RF: begin
					if ((ch_q != '0) && tail_room) begin
						tail_q <= tail_q + 1'b1;
					end
					if (chr_end) begin
						state_q <= S_POP;
					end else begin
						chr_q   <= chr_q + 1'b1;
						state_q <= S_RC;
					end
				end
				S_TG: begin
					scan_q  <= g_rdata;
					j_q     <= g_rdata;
					tjd_q   <= 1'b0;
					state_q <= S_TJ;
				end
				S_TJ: begin
					if (tjd_q) begin
						// node data is back: count it or stop at a consumed node
						tjd_q <= 1'b0;
						if (c_rdata) begin
							j_q <= '0;
						end else begin
							total_q <= sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
							j_q     <= f_rdata;
						end
					end else if (j_q == '0) begin
						if (cur_q.last) begin
							done_q  <= 1'b1;
							match_q <= total_q;
							total_q <= '0;
							scan_q  <= '0;
						end
						state_q <= S_IDLE;
					end else begin
						tjd_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	acpc_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	acpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	acpc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_endcnt (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	acpc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_consumed (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(j_q), .rdata(c_rdata)
	);

	acpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_bfsq (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);
endmodule

FILE: src/aho_corasick_pattern_counter.sv
// ----------------------------------------------------------------------------
// aho_corasick_pattern_counter
// Multi-pattern string counter built on an Aho-Corasick automaton.
// ----------------------------------------------------------------------------
// Send requests with start while busy is low. Opcode 0 adds a pattern symbol
// to the trie (last closes the pattern), opcode 1 builds the automaton, and
// opcode 2 scans a text symbol; the text symbol with last set produces one
// result on match_count and store_full, marked by done for a single cycle,
// with no way to hold it off, so capture it then. After reset, busy stays high
// while the goto, fail, end-count and consumed stores are wiped entirely.
// Requests land in a four-deep queue and drain into the engine, so after the
// clear busy only rises when that queue fills. The engine runs one request at
// a time, paced by the single read port of each store and its registered
// read: a pattern symbol reads its goto entry and adds a child if none, then
// on last reads and writes the end count; a text symbol reads its goto entry
// and the stores of each fail-chain node it visits, up to and including the
// first consumed one; a build walks the trie breadth first, reading the goto
// store twice per node and symbol. Dropped pattern symbols and out-of-range
// letters are handled in idle alone. Opcode 3 is dropped at intake.
// ----------------------------------------------------------------------------
module aho_corasick_pattern_counter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [1:0]                   opcode,
	input  logic [acpc_pkg::SYM_W-1:0]   symbol,
	input  logic                         last,
	output logic                         busy,
	output logic                         done,
	output logic [acpc_pkg::CNT_W-1:0]   match_count,
	output logic                         store_full
);
	import acpc_pkg::*;

	item_t item;
	logic  item_valid;
	logic  pop;
	logic  clearing;

	// intake: accept and queue requests
	acpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.symbol     (symbol),
		.last       (last),
		.hold       (clearing),
		.pop        (pop),
		.busy       (busy),
		.item_valid (item_valid),
		.item       (item)
	);

	// engine: run queued requests one at a time against the stores
	acpc_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.match_count (match_count),
		.store_full  (store_full)
	);
endmodule

FILE: src/acpc_checker.sv
// ----------------------------------------------------------------------------
// acpc_checker
// Port-level checks of the pattern counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acpc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic [1:0]                   opcode,
	input logic [acpc_pkg::SYM_W-1:0]   symbol,
	input logic                         last,
	input logic                         busy,
	input logic                         done,
	input logic [acpc_pkg::CNT_W-1:0]   match_count,
	input logic                         store_full
);
	`AC_ASSERT(a_full_sticky, store_full |=> store_full, "store_full dropped")
	`AC_ASSERT(a_result_known, done |-> !$isunknown({match_count, store_full}), "unknown result")
	`AC_ASSERT(a_req_known, (start && !busy) |-> !$isunknown({opcode, symbol, last}), "unknown request")
	`AC_ASSERT_ALWAYS(a_busy_known, !$isunknown(busy), "busy unknown")
endmodule

bind aho_corasick_pattern_counter acpc_checker u_acpc_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Aho-Corasick pattern counter.
// ----------------------------------------------------------------------------
// A behavioral copy of the automaton follows every request and predicts each result.
// The stimulus has three parts:
//   - a directed phase that inserts and builds a small pattern set and scans texts,
//   - random text scans over that set,
//   - after an idle pause, random text and stray requests.
// The monitor compares each done pulse against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import acpc_pkg::*;

	localparam int NCHAR = ALPHABET;

	typedef struct {
		logic [1:0]       opcode;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} req_t;

	typedef struct {
		logic [CNT_W-1:0] count;
		logic             full;
	} result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start = 1'b0;
	logic [1:0]          opcode = OP_NONE;
	logic [SYM_W-1:0]    symbol = '0;
	logic                last = 1'b0;
	logic                busy;
	logic                done;
	logic [CNT_W-1:0]    match_count;
	logic                store_full;

	aho_corasick_pattern_counter uut (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.symbol(symbol), .last(last), .busy(busy), .done(done),
		.match_count(match_count), .store_full(store_full)
	);

	always #4 clk = ~clk;

	// Automaton shadow state.
	int unsigned trie_next[MAX_NODES][NCHAR];
	int unsigned fail_of[MAX_NODES];
	int unsigned hits_at[MAX_NODES];
	bit          used_up[MAX_NODES];
	int unsigned bfs[$];
	int unsigned nodes_made, ins_at, scan_at, tally;
	bit          is_built, overflowed, pat_dropped;

	req_t    pending_reqs[$];
	result_t expected_counts[$];
	int      errors = 0;
	int      n_results = 0;
	bit      hold_for_drain = 0;

	// Update the automaton and queue any result one request produces.
	task automatic predict_request(input req_t r);
		int unsigned nx, u, f, j, steps;
		result_t res;
		if (r.opcode == OP_PATTERN && !is_built) begin
			if (!pat_dropped) begin
				if (r.symbol >= NCHAR) begin
					pat_dropped = 1;
				end else begin
					nx = trie_next[ins_at][r.symbol];
					if (nx == 0) begin
						if (nodes_made + 1 >= MAX_NODES) begin
							overflowed = 1;
							pat_dropped = 1;
						end else begin
							nodes_made++;
							nx = nodes_made;
							trie_next[ins_at][r.symbol] = nx;
						end
					end
					if (!pat_dropped) ins_at = nx;
				end
			end
			if (r.last) begin
				if (!pat_dropped && ins_at != 0 && hits_at[ins_at] < 65535)
					hits_at[ins_at]++;
				ins_at = 0;
				pat_dropped = 0;
			end
		end else if (r.opcode == OP_BUILD && !is_built) begin
			ins_at = 0;
			pat_dropped = 0;
			bfs.delete();
			for (int c = 0; c < NCHAR; c++)
				if (trie_next[0][c] != 0) bfs.push_back(trie_next[0][c]);
			while (bfs.size() > 0) begin
				u = bfs.pop_front();
				f = fail_of[u];
				for (int c = 0; c < NCHAR; c++) begin
					if (trie_next[u][c] != 0) begin
						fail_of[trie_next[u][c]] = trie_next[f][c];
						bfs.push_back(trie_next[u][c]);
					end else begin
						trie_next[u][c] = trie_next[f][c];
					end
				end
			end
			is_built = 1;
		end else if (r.opcode == OP_TEXT) begin
			if (r.symbol >= NCHAR) begin
				scan_at = 0;
			end else begin
				scan_at = trie_next[scan_at][r.symbol];
				j = scan_at;
				steps = 0;
				while (j != 0 && !used_up[j] && steps < MAX_NODES) begin
					tally += hits_at[j];
					if (tally > 65535) tally = 65535;
					used_up[j] = 1;
					j = fail_of[j];
					steps++;
				end
			end
			if (r.last) begin
				res.count = tally[CNT_W-1:0];
				res.full = overflowed;
				expected_counts.push_back(res);
				tally = 0;
				scan_at = 0;
			end
		end
	endtask

	function automatic req_t mk(input logic [1:0] op, input int sym, input bit lst);
		req_t r;
		r.opcode = op;
		r.symbol = SYM_W'(sym);
		r.last = lst;
		return r;
	endfunction

	// Queue a word of letters as a pattern or a text.
	task automatic add_word(input logic [1:0] op, input string w);
		for (int i = 0; i < w.len(); i++)
			pending_reqs.push_back(mk(op, w[i] - "a", i == w.len() - 1));
	endtask

	// Driver: hold each request until accepted, with random gaps.
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_request('{opcode, symbol, last});
			end
			if (start && busy) begin
				// hold the request
			end else if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (hold_for_drain && expected_counts.size() > 0) begin
				start <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_t r;
				r = pending_reqs.pop_front();
				start <= 1'b1;
				opcode <= r.opcode;
				symbol <= r.symbol;
				last <= r.last;
				gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each done pulse with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			result_t e;
			if (expected_counts.size() == 0) begin
				$error("unexpected result count=%0d", match_count);
				errors++;
			end else begin
				e = expected_counts.pop_front();
				n_results++;
				if (match_count !== e.count) begin
					$error("match_count expected %0d actual %0d", e.count, match_count);
					errors++;
				end
				if (store_full !== e.full) begin
					$error("store_full expected %0d actual %0d", e.full, store_full);
					errors++;
				end
			end
		end
	end

	string words[$] = '{"he", "she", "his", "hers", "a", "ab", "bab", "zz", "abc"};

	initial begin
		int len;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: text before build, pattern edge cases, build, texts.
		add_word(OP_TEXT, "she");
		pending_reqs.push_back(mk(OP_NONE, 31, 1));
		pending_reqs.push_back(mk(OP_PATTERN, 27, 0));
		pending_reqs.push_back(mk(OP_PATTERN, 0, 1));
		pending_reqs.push_back(mk(OP_PATTERN, 25, 1));
		foreach (words[i]) add_word(OP_PATTERN, words[i]);
		add_word(OP_PATTERN, "he");
		pending_reqs.push_back(mk(OP_PATTERN, 5, 0));
		pending_reqs.push_back(mk(OP_BUILD, 31, 1));
		pending_reqs.push_back(mk(OP_BUILD, 0, 0));
		add_word(OP_PATTERN, "x");
		add_word(OP_TEXT, "ushers");
		pending_reqs.push_back(mk(OP_TEXT, 30, 1));
		add_word(OP_TEXT, "zz");

		// Random texts mostly from a small alphabet so matches occur.
		while (pending_reqs.size() < 450) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				pending_reqs.push_back(mk(OP_TEXT,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
						: $urandom_range(0, 8), i == len - 1));
		end
		wait (pending_reqs.size() == 0 && !start);
		// Pause until the block has returned every pending result.
		hold_for_drain = 1;
		wait (expected_counts.size() == 0);
		hold_for_drain = 0;
		while (pending_reqs.size() < 300) begin
			pending_reqs.push_back(mk(2'($urandom_range(0, 3)), $urandom_range(0, 31),
				1'($urandom_range(0, 1))));
		end
		pending_reqs.push_back(mk(OP_TEXT, 0, 1));
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_counts.size() == 0);
		repeat (200) @(posedge clk);
		$display("Scanned directed and random texts over a built automaton: %0d results.",
			n_results);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
